// ----- rtl/lbfv_pkg.sv -----
// ----------------------------------------------------------------------------
// lbfv_pkg
// Shared widths, codes and types for the Lorentz boost core.
// ----------------------------------------------------------------------------
package lbfv_pkg;

	// Component width of every Q24.24 value.
	localparam int QW = 48;

	// Saturation bounds of a signed component.
	localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};

	// Pipeline depth of one saturating divider: sign strip, range check,
	// one quotient bit per stage, sign and saturation.
	localparam int DIV_LAT = QW + 3;

	// Multiplier operand width, split into two halves, and product width.
	localparam int MW   = 50;
	localparam int HALF = 25;
	localparam int PW   = 2 * MW;

	// Numerator widths of the energy division and the momentum division.
	localparam int NWA = 98;
	localparam int NWB = 97;

	// Configuration register indexes.
	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] CFG_ACTIVE = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_REF_E  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_REF_PX = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_REF_PY = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_REF_PZ = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_REF_M  = 3'd5;

	// Item data carried beside the arithmetic.
	typedef struct packed {
		logic                 func;
		logic signed [QW-1:0] e;
		logic signed [QW-1:0] px;
		logic signed [QW-1:0] py;
		logic signed [QW-1:0] pz;
	} side_t;

	typedef struct packed {
		side_t                sd;
		logic signed [QW-1:0] epr;
		logic                 ova;
	} side2_t;

	function automatic logic [MW-1:0] mag_w(input logic signed [MW-1:0] a);
		return a[MW-1] ? (~a + 1'b1) : a;
	endfunction

endpackage

// ----- rtl/lorentz_boost_four_vector_core.sv -----
// ----------------------------------------------------------------------------
// lorentz_boost_four_vector_core
// Boosts four-momenta into or out of the rest frame of a reference vector.
// ----------------------------------------------------------------------------
// The core takes one four-momentum per cycle and returns it boosted into the
// rest frame of the configured reference four-momentum (func low) or back out
// of it (func high), all components signed Q24.24. Every input transaction
// yields exactly one output transaction, in order. The pipeline depth is set
// by the two chained restoring dividers (the energy division by the mass,
// then the three momentum divisions by mass plus reference energy), each 51
// stages deep at one quotient bit per stage, plus the pipelined multipliers
// around them. The whole pipeline advances together
// and holds while the output transaction waits, so s_tready follows m_tready
// whenever a result is pending. Quotients or sums that leave the 48-bit range
// saturate and set the overflow flag. When the core is inactive, the mass is
// zero, or the mass cancels the reference energy, vectors pass unchanged.
// Configuration writes are taken at any time but must only be made while no
// transaction is in flight.
module lorentz_boost_four_vector_core
	import lbfv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Configuration write channel.
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [QW-1:0]     cfg_data,
	// Input stream.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [4*QW-1:0]   s_tdata,  // in_energy, in_px, in_py, in_pz
	input  logic [0:0]        s_tuser,  // func
	// Output stream.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [4*QW-1:0]   m_tdata,  // out_energy, out_px, out_py, out_pz
	output logic [0:0]        m_tuser   // overflow
);

	// ------------------------------------------------------------------
	// Configuration registers and values derived from them.
	// ------------------------------------------------------------------
	logic                 active_q;
	logic signed [QW-1:0] ref_e_q, ref_px_q, ref_py_q, ref_pz_q;
	logic [QW-2:0]        ref_m_q;
	logic [QW:0]          dmag_q;
	logic                 dneg_q;
	logic                 bypass_q;
	logic signed [QW:0]   den;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ref_e_q  <= 48'sd16777216;
			ref_px_q <= '0;
			ref_py_q <= '0;
			ref_pz_q <= '0;
			ref_m_q  <= 47'd16777216;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ACTIVE: active_q <= cfg_data[0];
				CFG_REF_E:  ref_e_q  <= $signed(cfg_data);
				CFG_REF_PX: ref_px_q <= $signed(cfg_data);
				CFG_REF_PY: ref_py_q <= $signed(cfg_data);
				CFG_REF_PZ: ref_pz_q <= $signed(cfg_data);
				CFG_REF_M:  ref_m_q  <= cfg_data[QW-2:0];
				default: ;
			endcase
		end
	end

	// Denominator of the momentum shift: mass plus reference energy.
	assign den = $signed({2'b00, ref_m_q}) + (QW+1)'(ref_e_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmag_q   <= 49'd33554432;
			dneg_q   <= 1'b0;
			bypass_q <= 1'b1;
		end else begin
			dmag_q   <= den[QW] ? (~den + 1'b1) : den;
			dneg_q   <= den[QW];
			bypass_q <= !active_q || (ref_m_q == '0) || (den == '0);
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control: all stages advance together.
	// ------------------------------------------------------------------
	logic adv;
	logic v_s11;

	assign adv      = !v_s11 || m_tready;
	assign s_tready = adv;

	function automatic logic [PW-1:0] pp_sum(input logic [MW-1:0] p0, input logic [MW-1:0] p1,
		input logic [MW-1:0] p2, input logic [MW-1:0] p3);
		return PW'(p0) + ((PW'(p1) + PW'(p2)) << HALF) + (PW'(p3) << MW);
	endfunction

	// ------------------------------------------------------------------
	// Stage 1: input register.
	// ------------------------------------------------------------------
	logic  v_s1;
	side_t sd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1.func <= s_tuser[0];
			sd_s1.e    <= $signed(s_tdata[QW-1:0]);
			sd_s1.px   <= $signed(s_tdata[2*QW-1:QW]);
			sd_s1.py   <= $signed(s_tdata[3*QW-1:2*QW]);
			sd_s1.pz   <= $signed(s_tdata[4*QW-1:3*QW]);
		end
	end

	// ------------------------------------------------------------------
	// Stages 2 to 4: the four products b0*E, bx*px, by*py, bz*pz as
	// half-width partial products, their sum, then the sign.
	// ------------------------------------------------------------------
	logic signed [MW-1:0] opa [4];
	logic signed [MW-1:0] opb [4];
	logic [MW-1:0]        ama [4];
	logic [MW-1:0]        amb [4];

	always_comb begin
		opa[0] = MW'(ref_e_q);
		opa[1] = MW'(ref_px_q);
		opa[2] = MW'(ref_py_q);
		opa[3] = MW'(ref_pz_q);
		opb[0] = MW'(sd_s1.e);
		opb[1] = MW'(sd_s1.px);
		opb[2] = MW'(sd_s1.py);
		opb[3] = MW'(sd_s1.pz);
		for (int k = 0; k < 4; k++) begin
			ama[k] = mag_w(opa[k]);
			amb[k] = mag_w(opb[k]);
		end
	end

	logic                  v_s2, v_s3, v_s4, v_s5, v_s6;
	side_t                 sd_s2, sd_s3, sd_s4, sd_s5, sd_s6;
	logic [MW-1:0]         pp_s2 [4][4];
	logic                  sg_s2 [4];
	logic [PW-1:0]         pm_s3 [4];
	logic                  sg_s3 [4];
	logic signed [NWA-1:0] pr_s4 [4];
	logic signed [NWA-1:0] t0_s5, dot_s5;
	logic signed [NWA-1:0] num_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				pp_s2[k][0] <= MW'(ama[k][HALF-1:0]) * MW'(amb[k][HALF-1:0]);
				pp_s2[k][1] <= MW'(ama[k][HALF-1:0]) * MW'(amb[k][MW-1:HALF]);
				pp_s2[k][2] <= MW'(ama[k][MW-1:HALF]) * MW'(amb[k][HALF-1:0]);
				pp_s2[k][3] <= MW'(ama[k][MW-1:HALF]) * MW'(amb[k][MW-1:HALF]);
				sg_s2[k]    <= opa[k][MW-1] ^ opb[k][MW-1];
				pm_s3[k]    <= pp_sum(pp_s2[k][0], pp_s2[k][1], pp_s2[k][2], pp_s2[k][3]);
				sg_s3[k]    <= sg_s2[k];
				pr_s4[k]    <= $signed(NWA'(sg_s3[k] ? (~{1'b0, pm_s3[k]} + 1'b1)
				                                     : {1'b0, pm_s3[k]}));
			end
			t0_s5  <= pr_s4[0];
			dot_s5 <= pr_s4[1] + pr_s4[2] + pr_s4[3];
			num_s6 <= sd_s5.func ? (t0_s5 + dot_s5) : (t0_s5 - dot_s5);
			sd_s2  <= sd_s1;
			sd_s3  <= sd_s2;
			sd_s4  <= sd_s3;
			sd_s5  <= sd_s4;
			sd_s6  <= sd_s5;
		end
	end

	// ------------------------------------------------------------------
	// Energy division by the mass, with the item data delayed alongside.
	// ------------------------------------------------------------------
	logic signed [QW-1:0] epa;
	logic                 ova;
	logic [DIV_LAT-1:0]   vda;
	side_t                dla_s [DIV_LAT];

	lbfv_sdiv #(
		.NW(NWA),
		.DW(QW-1)
	) u_div_e (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.num    (num_s6),
		.dmag   (ref_m_q),
		.dneg   (1'b0),
		.quo    (epa),
		.ovf    (ova)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vda <= '0;
		end else if (adv) begin
			vda <= {vda[DIV_LAT-2:0], v_s6};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dla_s[0] <= sd_s6;
			for (int k = 1; k < DIV_LAT; k++) begin
				dla_s[k] <= dla_s[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: s = E + E'. Stages 8 to 10: the three products s*b_i.
	// ------------------------------------------------------------------
	logic                 v_s7, v_s8, v_s9, v_s10;
	side2_t               sd_s7, sd_s8, sd_s9, sd_s10;
	logic signed [QW:0]   s_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s7  <= vda[DIV_LAT-1];
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	logic signed [MW-1:0] opb2 [3];
	logic [MW-1:0]        ams;
	logic [MW-1:0]        amb2 [3];

	always_comb begin
		opb2[0] = MW'(ref_px_q);
		opb2[1] = MW'(ref_py_q);
		opb2[2] = MW'(ref_pz_q);
		ams     = mag_w(MW'(s_s7));
		for (int k = 0; k < 3; k++) begin
			amb2[k] = mag_w(opb2[k]);
		end
	end

	logic [MW-1:0]         pp_s8 [3][4];
	logic                  sg_s8 [3];
	logic [PW-1:0]         pm_s9 [3];
	logic                  sg_s9 [3];
	logic signed [NWB-1:0] pr_s10 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s7         <= (QW+1)'(dla_s[DIV_LAT-1].e) + (QW+1)'(epa);
			sd_s7.sd     <= dla_s[DIV_LAT-1];
			sd_s7.epr    <= epa;
			sd_s7.ova    <= ova;
			for (int k = 0; k < 3; k++) begin
				pp_s8[k][0] <= MW'(ams[HALF-1:0]) * MW'(amb2[k][HALF-1:0]);
				pp_s8[k][1] <= MW'(ams[HALF-1:0]) * MW'(amb2[k][MW-1:HALF]);
				pp_s8[k][2] <= MW'(ams[MW-1:HALF]) * MW'(amb2[k][HALF-1:0]);
				pp_s8[k][3] <= MW'(ams[MW-1:HALF]) * MW'(amb2[k][MW-1:HALF]);
				sg_s8[k]    <= s_s7[QW] ^ opb2[k][MW-1];
				pm_s9[k]    <= pp_sum(pp_s8[k][0], pp_s8[k][1], pp_s8[k][2], pp_s8[k][3]);
				sg_s9[k]    <= sg_s8[k];
				pr_s10[k]   <= $signed(NWB'(sg_s9[k] ? (~{1'b0, pm_s9[k]} + 1'b1)
				                                     : {1'b0, pm_s9[k]}));
			end
			sd_s8  <= sd_s7;
			sd_s9  <= sd_s8;
			sd_s10 <= sd_s9;
		end
	end

	// ------------------------------------------------------------------
	// Momentum divisions by mass plus reference energy, three lanes.
	// ------------------------------------------------------------------
	logic signed [QW-1:0] qb [3];
	logic                 ovb [3];
	logic [DIV_LAT-1:0]   vdb;
	side2_t               dlb_s [DIV_LAT];

	for (genvar i = 0; i < 3; i++) begin : g_div_p
		lbfv_sdiv #(
			.NW(NWB),
			.DW(QW+1)
		) u_div_p (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.num    (pr_s10[i]),
			.dmag   (dmag_q),
			.dneg   (dneg_q),
			.quo    (qb[i]),
			.ovf    (ovb[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vdb <= '0;
		end else if (adv) begin
			vdb <= {vdb[DIV_LAT-2:0], v_s10};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dlb_s[0] <= sd_s10;
			for (int k = 1; k < DIV_LAT; k++) begin
				dlb_s[k] <= dlb_s[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 11: final add or subtract with saturation, pass-through
	// select, and the output register.
	// ------------------------------------------------------------------
	side2_t               fin;
	logic signed [QW-1:0] pin [3];
	logic signed [QW:0]   sum [3];
	logic signed [QW-1:0] pout [3];
	logic                 sov [3];

	always_comb begin
		fin    = dlb_s[DIV_LAT-1];
		pin[0] = fin.sd.px;
		pin[1] = fin.sd.py;
		pin[2] = fin.sd.pz;
		for (int k = 0; k < 3; k++) begin
			sum[k] = fin.sd.func ? ((QW+1)'(pin[k]) + (QW+1)'(qb[k]))
			                     : ((QW+1)'(pin[k]) - (QW+1)'(qb[k]));
			sov[k] = sum[k][QW] ^ sum[k][QW-1];
			pout[k] = sov[k] ? (sum[k][QW] ? QMIN : QMAX) : sum[k][QW-1:0];
		end
	end

	logic signed [QW-1:0] re_s11;
	logic signed [QW-1:0] rp_s11 [3];
	logic                 ovf_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s11 <= vdb[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (bypass_q) begin
				re_s11    <= fin.sd.e;
				rp_s11[0] <= fin.sd.px;
				rp_s11[1] <= fin.sd.py;
				rp_s11[2] <= fin.sd.pz;
				ovf_s11   <= 1'b0;
			end else begin
				re_s11    <= fin.epr;
				rp_s11[0] <= pout[0];
				rp_s11[1] <= pout[1];
				rp_s11[2] <= pout[2];
				ovf_s11   <= fin.ova || ovb[0] || ovb[1] || ovb[2]
				             || sov[0] || sov[1] || sov[2];
			end
		end
	end

	assign m_tvalid   = v_s11;
	assign m_tdata    = {rp_s11[2], rp_s11[1], rp_s11[0], re_s11};
	assign m_tuser[0] = ovf_s11;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted transaction did not enter the first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vda) && $stable(vdb))
		else $error("divider valid bits moved during a stall");

	a_energy_sat: assert property (@(posedge clk) disable iff (!arst_n)
		vda[DIV_LAT-1] && ova |-> (epa == QMAX || epa == QMIN))
		else $error("energy overflow without a saturated quotient");

endmodule

// ----- rtl/lbfv_sdiv.sv -----
// ----------------------------------------------------------------------------
// lbfv_sdiv
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero and saturating the quotient to the signed component range.
// ----------------------------------------------------------------------------
module lbfv_sdiv
	import lbfv_pkg::*;
#(
	parameter int NW = 98,
	parameter int DW = 47
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        dmag,
	input  logic                 dneg,
	output logic signed [QW-1:0] quo,
	output logic                 ovf
);

	localparam int HW = NW - QW;
	localparam int CW = ((HW > DW) ? HW : DW) + 1;

	logic [NW-1:0] nm_s0;
	logic          neg_s0;
	logic [DW-1:0] rem_s [QW+1];
	logic [QW-1:0] lq_s  [QW+1];
	logic          ov_s  [QW+1];
	logic          ng_s  [QW+1];

	logic [HW-1:0] hi;
	logic          hi_ovf;

	always_ff @(posedge clk) begin
		if (en) begin
			nm_s0  <= num[NW-1] ? (~num + 1'b1) : num;
			neg_s0 <= num[NW-1] ^ dneg;
		end
	end

	// The quotient fits the component width exactly when the part of the
	// numerator above the fraction bits is below the divisor.
	always_comb begin
		hi     = nm_s0[NW-1:QW];
		hi_ovf = (CW'(hi) >= CW'(dmag));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_s[0] <= 1'b0;
		end else if (en) begin
			ov_s[0] <= hi_ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= hi_ovf ? '0 : DW'(hi);
			lq_s[0]  <= nm_s0[QW-1:0];
			ng_s[0]  <= neg_s0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0]   r2;
		logic [DW+1:0] diff;
		logic          take;

		always_comb begin
			r2   = {rem_s[k], lq_s[k][QW-1]};
			diff = {1'b0, r2} - {2'b0, dmag};
			take = ~diff[DW+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ov_s[k+1] <= 1'b0;
			end else if (en) begin
				ov_s[k+1] <= ov_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? diff[DW-1:0] : r2[DW-1:0];
				lq_s[k+1]  <= {lq_s[k][QW-2:0], take};
				ng_s[k+1]  <= ng_s[k];
			end
		end
	end

	logic [QW-1:0] qm;
	logic          sat;

	always_comb begin
		qm  = lq_s[QW];
		sat = ov_s[QW] || (ng_s[QW] ? (qm[QW-1] && (|qm[QW-2:0])) : qm[QW-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf <= 1'b0;
		end else if (en) begin
			ovf <= sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sat) begin
				quo <= ng_s[QW] ? QMIN : QMAX;
			end else begin
				quo <= ng_s[QW] ? $signed(~qm + 1'b1) : $signed(qm);
			end
		end
	end

endmodule
